// File: rtl/wopt_pkg.sv
// ----------------------------------------------------------------------------
// wopt_pkg: shared types and constants of the wheel odometry pose tracker
// Holds the motion codes, register indexes, controller states and the
// arctangent table of the shift-and-add sine/cosine unit.
// ----------------------------------------------------------------------------
package wopt_pkg;

    typedef enum logic [1:0] {
        MOTION_IDLE   = 2'd0,
        MOTION_LINEAR = 2'd1,
        MOTION_LEFT   = 2'd2,
        MOTION_RIGHT  = 2'd3
    } motion_t;

    localparam logic REG_DISTANCE = 1'b0;
    localparam logic REG_ANGLE    = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ROT,
        ST_PROJ,
        ST_DONE
    } state_t;

    localparam int AtanCount = 24;
    localparam logic signed [34:0] GainQ30 = 35'sd652032874;

    function automatic logic [31:0] atan_lookup(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/wheel_odometry_pose_tracker_core.sv
// ----------------------------------------------------------------------------
// wheel_odometry_pose_tracker_core: dead-reckoning pose tracker
// Integrates wheel encoder deltas into a Q16.16 X/Y position and a binary
// angle heading, one pose transfer out for every item transfer in.
// ----------------------------------------------------------------------------
// One item is worked on at a time. An idle item goes from input transfer
// straight to the final state. A turn item runs a bit-serial multiply of
// the tick sum by angle_per_tick, then the final state. A linear item runs
// the same serial multiply for the distance, then the rotation unit (one
// rotation a cycle), then a bit-serial projection that forms both X and Y
// products at once. The result sits in an output register; a new item is
// taken once it has been transferred. Configuration writes are taken in
// any cycle.
// ----------------------------------------------------------------------------
module wheel_odometry_pose_tracker_core #(
    parameter int ANGLE_BITS = 16,
    parameter int TRIG_STEPS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // tdata: motion[1:0], left_ticks[14:2], right_ticks[27:15],
    //        back_ticks[40:28], front_ticks[53:41], zero fill [55:54]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,
    // tdata: pos_x[31:0], pos_y[63:32], heading[79:64]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int Steps = (TRIG_STEPS < wopt_pkg::AtanCount) ? TRIG_STEPS
                                                            : wopt_pkg::AtanCount;
    localparam logic [ANGLE_BITS-1:0] HeadReset = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

    // configuration
    logic [15:0] dist_reg, angle_reg;
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dist_reg  <= '0;
            angle_reg <= '0;
        end else if (cfg_valid) begin
            if (cfg_index == wopt_pkg::REG_DISTANCE) dist_reg <= cfg_data;
            else                                     angle_reg <= cfg_data;
        end
    end

    // pose state
    logic [31:0]           x_reg, y_reg, x_next, y_next;
    logic [ANGLE_BITS-1:0] head_reg, head_next;
    wopt_pkg::state_t      state_reg, state_next;
    wopt_pkg::motion_t     motion_reg, motion_next;
    logic [5:0]            cnt_reg, cnt_next;

    // serial multiply: accumulate multiplicand shifted by multiplier bit
    logic signed [15:0] sum_reg, sum_next;          // tick sum
    logic [15:0]        mplr_reg, mplr_next;        // config operand, shifted out
    logic signed [31:0] prod_reg, prod_next;        // product

    // rotation unit
    logic signed [34:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [32:0] z_reg, z_next;

    // projection: distance shifted out bit-serially (two's complement)
    logic [34:0]        dsh_reg, dsh_next;
    logic signed [67:0] px_reg, px_next, py_reg, py_next;

    logic [31:0] res_x_reg, res_y_reg, res_x_next, res_y_next;
    logic [15:0] res_h_reg, res_h_next;
    logic        mval_reg, mval_next;

    logic signed [12:0] l_in, r_in, b_in, f_in;
    assign l_in = s_tdata[14:2];
    assign r_in = s_tdata[27:15];
    assign b_in = s_tdata[40:28];
    assign f_in = s_tdata[53:41];

    assign s_tready = (state_reg == wopt_pkg::ST_IDLE) && !mval_reg;
    assign m_tvalid = mval_reg;
    assign m_tdata  = {res_h_reg, res_y_reg, res_x_reg};

    logic [31:0]        z32;
    logic [1:0]         quad;
    logic signed [34:0] xs, ys;
    logic [31:0]        at;
    logic signed [67:0] addx, addy;
    logic signed [32:0] dist_w;
    logic [ANGLE_BITS-1:0] ang;
    logic [15:0]        hout;

    always_comb begin
        state_next  = state_reg;
        motion_next = motion_reg;
        cnt_next    = cnt_reg;
        sum_next    = sum_reg;
        mplr_next   = mplr_reg;
        prod_next   = prod_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        z_next      = z_reg;
        dsh_next    = dsh_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        head_next   = head_reg;
        res_x_next  = res_x_reg;
        res_y_next  = res_y_reg;
        res_h_next  = res_h_reg;
        mval_next   = mval_reg && !m_tready;
        z32 = 32'(head_reg) << (32 - ANGLE_BITS);
        quad = z32[31:30];
        xs = cx_reg >>> cnt_reg[4:0];
        ys = cy_reg >>> cnt_reg[4:0];
        at = wopt_pkg::atan_lookup(cnt_reg[4:0]);
        addx = '0;
        addy = '0;
        dist_w = '0;
        // floor of product / 1024, sign carried into wide headings
        ang = ANGLE_BITS'(prod_reg >>> 10);
        if (ANGLE_BITS >= 16) hout = 16'(head_reg >> (ANGLE_BITS - 16));
        else                  hout = 16'(32'(head_reg) << (16 - ANGLE_BITS));

        unique case (state_reg)
            wopt_pkg::ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    motion_next = wopt_pkg::motion_t'(s_tdata[1:0]);
                    cnt_next    = '0;
                    prod_next   = '0;
                    if (s_tdata[1:0] == wopt_pkg::MOTION_LINEAR) begin
                        sum_next  = 16'(l_in) + 16'(r_in);
                        mplr_next = dist_reg;
                        state_next = wopt_pkg::ST_MUL;
                    end else if (s_tdata[1:0] == wopt_pkg::MOTION_IDLE) begin
                        state_next = wopt_pkg::ST_DONE;
                    end else begin
                        sum_next  = 16'(l_in) + 16'(r_in) + 16'(b_in) + 16'(f_in);
                        mplr_next = angle_reg;
                        state_next = wopt_pkg::ST_MUL;
                    end
                end
            end
            wopt_pkg::ST_MUL: begin
                // add sum << cnt when the current multiplier bit is set
                if (mplr_reg[0])
                    prod_next = prod_reg + (32'(sum_reg) <<< cnt_reg[3:0]);
                mplr_next = mplr_reg >> 1;
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg == 6'd15) begin
                    cnt_next = '0;
                    if (motion_reg == wopt_pkg::MOTION_LINEAR) begin
                        if (quad == 2'd1 || quad == 2'd2) begin
                            cx_next = -wopt_pkg::GainQ30;
                            z_next  = 33'(signed'(z32 + 32'h8000_0000));
                        end else begin
                            cx_next = wopt_pkg::GainQ30;
                            z_next  = 33'(signed'(z32));
                        end
                        cy_next = '0;
                        state_next = wopt_pkg::ST_ROT;
                    end else begin
                        state_next = wopt_pkg::ST_DONE;
                    end
                end
            end
            wopt_pkg::ST_ROT: begin
                if (!z_reg[32]) begin
                    cx_next = cx_reg - ys;
                    cy_next = cy_reg + xs;
                    z_next  = z_reg - 33'(at);
                end else begin
                    cx_next = cx_reg + ys;
                    cy_next = cy_reg - xs;
                    z_next  = z_reg + 33'(at);
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(Steps - 1)) begin
                    cnt_next  = '0;
                    dist_w    = 33'(prod_reg);
                    dsh_next  = 35'(dist_w >>> 1);
                    px_next   = '0;
                    py_next   = '0;
                    state_next = wopt_pkg::ST_PROJ;
                end
            end
            wopt_pkg::ST_PROJ: begin
                // distance bit k adds cos,sin << k; the sign bit subtracts
                addx = 68'(cx_reg) <<< cnt_reg;
                addy = 68'(cy_reg) <<< cnt_reg;
                if (dsh_reg[0]) begin
                    if (cnt_reg == 6'd34) begin
                        px_next = px_reg - addx;
                        py_next = py_reg - addy;
                    end else begin
                        px_next = px_reg + addx;
                        py_next = py_reg + addy;
                    end
                end
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd34) state_next = wopt_pkg::ST_DONE;
            end
            wopt_pkg::ST_DONE: begin
                if (motion_reg == wopt_pkg::MOTION_LINEAR) begin
                    x_next = x_reg + px_reg[61:30];
                    y_next = y_reg + py_reg[61:30];
                    res_x_next = x_next;
                    res_y_next = y_next;
                    res_h_next = hout;
                end else begin
                    if (motion_reg == wopt_pkg::MOTION_LEFT)  head_next = head_reg + ang;
                    if (motion_reg == wopt_pkg::MOTION_RIGHT) head_next = head_reg - ang;
                    res_x_next = x_reg;
                    res_y_next = y_reg;
                    if (ANGLE_BITS >= 16) res_h_next = 16'(head_next >> (ANGLE_BITS - 16));
                    else res_h_next = 16'(32'(head_next) << (16 - ANGLE_BITS));
                end
                mval_next  = 1'b1;
                state_next = wopt_pkg::ST_IDLE;
            end
            default: state_next = wopt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= wopt_pkg::ST_IDLE;
            mval_reg   <= 1'b0;
            x_reg      <= '0;
            y_reg      <= '0;
            head_reg   <= HeadReset;
            motion_reg <= wopt_pkg::MOTION_IDLE;
            cnt_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            mval_reg   <= mval_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            head_reg   <= head_next;
            motion_reg <= motion_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg   <= sum_next;
        mplr_reg  <= mplr_next;
        prod_reg  <= prod_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        z_reg     <= z_next;
        dsh_reg   <= dsh_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        res_x_reg <= res_x_next;
        res_y_reg <= res_y_next;
        res_h_reg <= res_h_next;
    end

    // a result is only raised from the final state
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(mval_reg) |-> $past(state_reg) == wopt_pkg::ST_DONE)
        else $error("result raised outside final state");
    // no input transfer while a result waits
    assert property (@(posedge aclk) disable iff (!aresetn)
        mval_reg |-> !s_tready)
        else $error("input ready while result pending");
    // x position and heading hold while a result waits
    assert property (@(posedge aclk) disable iff (!aresetn)
        mval_reg && $past(mval_reg) |-> $stable(x_reg) && $stable(head_reg))
        else $error("pose moved while result pending");

endmodule
